// ===== rtl/ptfd_pkg.sv =====
`timescale 1ns / 1ps
package ptfd_pkg;

   localparam int FRAME_BYTES  = 9;
   localparam int FRAC_BITS    = 8;
   localparam int BYTE_W       = 8;
   localparam int WORD_W       = 16;
   localparam int QUO_W        = WORD_W + FRAC_BITS;
   localparam int CNT_W        = $clog2(QUO_W + 1);
   localparam int POS_W        = $clog2(FRAME_BYTES + 1);
   localparam int PRES_W       = 24;
   localparam int TEMP_W       = 17;
   localparam int TEMP_DIVISOR = 200;

   localparam int PRES_MAX = (1 << (PRES_W - 1)) - 1;
   localparam int PRES_MIN = -(1 << (PRES_W - 1));
   localparam int TEMP_MAX = (1 << (TEMP_W - 1)) - 1;
   localparam int TEMP_MIN = -(1 << (TEMP_W - 1));

   // Byte positions within the measurement frame.
   localparam logic [POS_W-1:0] POS_PRES_HI  = POS_W'(0);
   localparam logic [POS_W-1:0] POS_PRES_LO  = POS_W'(1);
   localparam logic [POS_W-1:0] POS_TEMP_HI  = POS_W'(3);
   localparam logic [POS_W-1:0] POS_TEMP_LO  = POS_W'(4);
   localparam logic [POS_W-1:0] POS_SCALE_HI = POS_W'(6);
   localparam logic [POS_W-1:0] POS_SCALE_LO = POS_W'(7);
   localparam logic [POS_W-1:0] POS_LAST     = POS_W'(FRAME_BYTES - 1);
   localparam logic [POS_W-1:0] POS_END      = POS_W'(FRAME_BYTES);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV_P,
      ST_DIV_T,
      ST_EMIT
   } ptfd_state_type;

   typedef struct packed {
      logic              start;
      logic [QUO_W-1:0]  dividend;
      logic [WORD_W-1:0] divisor;
   } ptfd_div_req_type;

   typedef struct packed {
      logic             busy;
      logic             done;
      logic [QUO_W-1:0] quotient;
   } ptfd_div_res_type;

endpackage

// ===== rtl/ptfd_req_if.sv =====
`timescale 1ns / 1ps
interface ptfd_req_if import ptfd_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [BYTE_W-1:0] data_byte;
   logic              frame_start;

   modport source (output valid, output data_byte, output frame_start, input ready);
   modport sink (input valid, input data_byte, input frame_start, output ready);
endinterface

// ===== rtl/ptfd_rsp_if.sv =====
`timescale 1ns / 1ps
interface ptfd_rsp_if import ptfd_pkg::*; ();
   logic                     valid;
   logic                     ready;
   logic signed [PRES_W-1:0] pressure_q;
   logic signed [TEMP_W-1:0] temperature_q;
   logic                     pressure_valid;

   modport source (output valid, output pressure_q, output temperature_q,
                   output pressure_valid, input ready);
   modport sink (input valid, input pressure_q, input temperature_q,
                 input pressure_valid, output ready);
endinterface

// ===== rtl/ptfd_csr_if.sv =====
`timescale 1ns / 1ps
interface ptfd_csr_if;
   logic valid;
   logic ready;
   logic data;

   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/ptfd_div.sv =====
`timescale 1ns / 1ps
module ptfd_div
   import ptfd_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  ptfd_div_req_type div_req,
   output ptfd_div_res_type div_res
);

   logic [WORD_W-1:0] rem_ff, rem_in;
   logic [WORD_W-1:0] div_ff, div_in;
   logic [QUO_W-1:0]  quo_ff, quo_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              busy_ff, busy_in;
   logic              done_ff, done_in;
   logic [WORD_W:0]   rem_shift;
   logic [WORD_W:0]   rem_diff;
   logic              fits;

   // Restoring division, one quotient bit per cycle. The dividend shifts out of
   // the top of quo_ff while the quotient bits shift in at the bottom.
   always_comb begin
      rem_shift = {rem_ff, quo_ff[QUO_W-1]};
      rem_diff  = rem_shift - {1'b0, div_ff};
      fits      = (rem_shift >= {1'b0, div_ff});
      rem_in    = rem_ff;
      div_in    = div_ff;
      quo_in    = quo_ff;
      cnt_in    = cnt_ff;
      busy_in   = busy_ff;
      done_in   = 1'b0;
      if (div_req.start) begin
         rem_in  = '0;
         div_in  = div_req.divisor;
         quo_in  = div_req.dividend;
         cnt_in  = CNT_W'(QUO_W);
         busy_in = 1'b1;
      end else if (busy_ff) begin
         rem_in = fits ? rem_diff[WORD_W-1:0] : rem_shift[WORD_W-1:0];
         quo_in = {quo_ff[QUO_W-2:0], fits};
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff  <= '0;
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         cnt_ff  <= cnt_in;
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      div_ff <= div_in;
      quo_ff <= quo_in;
   end

   assign div_res.busy     = busy_ff;
   assign div_res.done     = done_ff;
   assign div_res.quotient = quo_ff;

endmodule

// ===== rtl/pressure_temp_frame_decoder_unit.sv =====
`timescale 1ns / 1ps
// A byte that does not close an enabled frame is accepted; ready stays high.
// The closing byte of an enabled frame starts the shared 24-step divider; ready stays low
// until the result enters the output register, which waits while an earlier one is untaken.
// Per frame: 9 byte transfers, then divides of pressure (not at zero scale) and temperature.
// Synchronous active-high reset clears enable, the byte position and the held pressure.
module pressure_temp_frame_decoder_unit
   import ptfd_pkg::*;
(
   input logic        clock,
   input logic        reset,
   ptfd_req_if.sink   req_chan,
   ptfd_rsp_if.source rsp_chan,
   ptfd_csr_if.sink   csr_chan
);

   ptfd_state_type state_ff, state_in;

   logic              enable_ff, enable_in;
   logic [POS_W-1:0]  pos_ff, pos_in;
   logic [POS_W-1:0]  cur_pos;
   logic [WORD_W-1:0] raw_p_ff, raw_p_in;
   logic [WORD_W-1:0] raw_t_ff, raw_t_in;
   logic [BYTE_W-1:0] scale_hi_ff, scale_hi_in;
   logic [BYTE_W-1:0] scale_lo_ff, scale_lo_in;
   logic [PRES_W-1:0] held_ff, held_in;
   logic [TEMP_W-1:0] temp_res_ff, temp_res_in;
   logic              pvalid_ff, pvalid_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [PRES_W-1:0] rsp_pres_ff, rsp_pres_in;
   logic [TEMP_W-1:0] rsp_temp_ff, rsp_temp_in;
   logic              rsp_pvalid_ff, rsp_pvalid_in;

   logic                    req_xfer;
   logic [WORD_W-1:0]       scale;
   logic [WORD_W-1:0]       mag_p;
   logic [WORD_W-1:0]       mag_t;
   logic                    quo_neg;
   logic signed [QUO_W:0]   quo_signed;
   logic [PRES_W-1:0]       pres_sat;
   logic [TEMP_W-1:0]       temp_sat;

   ptfd_div_req_type div_req;
   ptfd_div_res_type div_res;

   ptfd_div u_div (
      .clock   (clock),
      .reset   (reset),
      .div_req (div_req),
      .div_res (div_res)
   );

   assign req_chan.ready = (state_ff == ST_IDLE);
   assign csr_chan.ready = 1'b1;
   assign req_xfer       = req_chan.valid && req_chan.ready;
   assign enable_in      = (csr_chan.valid && csr_chan.ready) ? csr_chan.data : enable_ff;

   assign cur_pos = req_chan.frame_start ? POS_PRES_HI : pos_ff;
   assign scale   = {scale_hi_ff, scale_lo_ff};
   assign mag_p   = raw_p_ff[WORD_W-1] ? WORD_W'(-raw_p_ff) : raw_p_ff;
   assign mag_t   = raw_t_ff[WORD_W-1] ? WORD_W'(-raw_t_ff) : raw_t_ff;

   // Sign is restored after the unsigned division, then the result is clamped.
   always_comb begin
      quo_neg    = (state_ff == ST_DIV_P) ? raw_p_ff[WORD_W-1] : raw_t_ff[WORD_W-1];
      quo_signed = quo_neg ? -$signed({1'b0, div_res.quotient})
                           : $signed({1'b0, div_res.quotient});
      if (quo_signed > (QUO_W+1)'(PRES_MAX)) begin
         pres_sat = PRES_W'(PRES_MAX);
      end else if (quo_signed < (QUO_W+1)'(PRES_MIN)) begin
         pres_sat = PRES_W'(PRES_MIN);
      end else begin
         pres_sat = quo_signed[PRES_W-1:0];
      end
      if (quo_signed > (QUO_W+1)'(TEMP_MAX)) begin
         temp_sat = TEMP_W'(TEMP_MAX);
      end else if (quo_signed < (QUO_W+1)'(TEMP_MIN)) begin
         temp_sat = TEMP_W'(TEMP_MIN);
      end else begin
         temp_sat = quo_signed[TEMP_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      raw_p_in      = raw_p_ff;
      raw_t_in      = raw_t_ff;
      scale_hi_in   = scale_hi_ff;
      scale_lo_in   = scale_lo_ff;
      held_in       = held_ff;
      temp_res_in   = temp_res_ff;
      pvalid_in     = pvalid_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_pres_in   = rsp_pres_ff;
      rsp_temp_in   = rsp_temp_ff;
      rsp_pvalid_in = rsp_pvalid_ff;
      div_req       = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               pos_in = cur_pos;
               if (cur_pos != POS_END) begin
                  pos_in = cur_pos + 1'b1;
                  unique case (cur_pos)
                     POS_PRES_HI:  raw_p_in[WORD_W-1:BYTE_W] = req_chan.data_byte;
                     POS_PRES_LO:  raw_p_in[BYTE_W-1:0]      = req_chan.data_byte;
                     POS_TEMP_HI:  raw_t_in[WORD_W-1:BYTE_W] = req_chan.data_byte;
                     POS_TEMP_LO:  raw_t_in[BYTE_W-1:0]      = req_chan.data_byte;
                     POS_SCALE_HI: scale_hi_in               = req_chan.data_byte;
                     POS_SCALE_LO: scale_lo_in               = req_chan.data_byte;
                     default: ;
                  endcase
                  if (cur_pos == POS_LAST && enable_ff) begin
                     div_req.start = 1'b1;
                     if (scale != '0) begin
                        div_req.dividend = {mag_p, {FRAC_BITS{1'b0}}};
                        div_req.divisor  = scale;
                        pvalid_in        = 1'b1;
                        state_in         = ST_DIV_P;
                     end else begin
                        div_req.dividend = {mag_t, {FRAC_BITS{1'b0}}};
                        div_req.divisor  = WORD_W'(TEMP_DIVISOR);
                        pvalid_in        = 1'b0;
                        state_in         = ST_DIV_T;
                     end
                  end
               end
            end
         end
         ST_DIV_P: begin
            if (div_res.done) begin
               held_in          = pres_sat;
               div_req.start    = 1'b1;
               div_req.dividend = {mag_t, {FRAC_BITS{1'b0}}};
               div_req.divisor  = WORD_W'(TEMP_DIVISOR);
               state_in         = ST_DIV_T;
            end
         end
         ST_DIV_T: begin
            if (div_res.done) begin
               temp_res_in = temp_sat;
               state_in    = ST_EMIT;
            end
         end
         ST_EMIT: begin
            // Waits here while an earlier result has not yet been taken.
            if (!rsp_valid_ff || rsp_chan.ready) begin
               rsp_valid_in  = 1'b1;
               rsp_pres_in   = held_ff;
               rsp_temp_in   = temp_res_ff;
               rsp_pvalid_in = pvalid_ff;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         enable_ff    <= 1'b0;
         pos_ff       <= '0;
         held_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         enable_ff    <= enable_in;
         pos_ff       <= pos_in;
         held_ff      <= held_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      raw_p_ff      <= raw_p_in;
      raw_t_ff      <= raw_t_in;
      scale_hi_ff   <= scale_hi_in;
      scale_lo_ff   <= scale_lo_in;
      temp_res_ff   <= temp_res_in;
      pvalid_ff     <= pvalid_in;
      rsp_pres_ff   <= rsp_pres_in;
      rsp_temp_ff   <= rsp_temp_in;
      rsp_pvalid_ff <= rsp_pvalid_in;
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.pressure_q     = rsp_pres_ff;
   assign rsp_chan.temperature_q  = rsp_temp_ff;
   assign rsp_chan.pressure_valid = rsp_pvalid_ff;

`ifndef ASSERT_OFF
   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff <= POS_END)
      else $error("byte position beyond frame length");

   a_start_idle_div: assert property (@(posedge clock) disable iff (reset)
      div_req.start |-> !div_res.busy)
      else $error("divider started while busy");

   a_done_in_div: assert property (@(posedge clock) disable iff (reset)
      div_res.done |-> (state_ff == ST_DIV_P || state_ff == ST_DIV_T))
      else $error("divider finished outside a divide state");

   a_rsp_from_emit: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_EMIT))
      else $error("result raised without leaving the emit state");
`endif

endmodule
